@@ hdl/seven_segment_mux_display_macros.svh @@
// assertion macros for the seven-segment display driver checker
// no dependencies; included by files that hold concurrent assertions
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_MACROS_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_MACROS_SVH

// implication checked on aclk, disabled while aresetn is low
`define SSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on aclk, disabled while aresetn is low
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define SSD_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ssd_pkg.sv @@
// shared types, codes and glyph table of the seven-segment display driver
// no dependencies
package ssd_pkg;

    typedef enum logic [1:0] {
        OP_SET_DIGIT  = 2'd0,
        OP_SET_NUMBER = 2'd1,
        OP_TICK       = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WRITE,
        ST_SIGN
    } state_t;

    typedef struct packed {
        logic set_digit;
        logic tick;
        logic load_number;
        logic divide;
        logic write_digit;
        logic write_sign;
    } cmd_t;

    typedef struct packed {
        logic number_ok;
        logic quot_zero;
        logic negative;
    } status_t;

    localparam int MAG_W  = 14;
    localparam int QUOT_W = 10;
    localparam int POS_W  = 3;

    localparam logic [12:0]        RECIP_TEN     = 13'd6554;
    localparam logic signed [15:0] NUMBER_HIGH   = 16'sd10000;
    localparam logic signed [15:0] NUMBER_LOW    = -16'sd1000;
    localparam logic signed [4:0]  VALUE_MIN     = -5'sd1;
    localparam logic signed [4:0]  VALUE_MAX     = 5'sd9;
    localparam logic [7:0]         MINUS_PATTERN = 8'h40;
    localparam logic [7:0]         DOT_MASK      = 8'h80;

    function automatic logic [7:0] glyph(input logic [3:0] value);
        logic [7:0] pat;
        unique case (value)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ hdl/ssd_ctrl.sv @@
// controller: handshake, output valid and the number-conversion sequencer
// depends on ssd_pkg
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_operation,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == ST_IDLE)
                   && ((s_operation != OP_TICK) || !m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.set_digit    = accept && (s_operation == OP_SET_DIGIT);
        cmd.tick         = accept && (s_operation == OP_TICK);
        m_valid_next     = m_valid_reg;
        if (cmd.tick) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_operation == OP_SET_NUMBER) && status.number_ok) begin
                    cmd.load_number = 1'b1;
                    state_next      = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.divide = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.write_digit = 1'b1;
                if (!status.quot_zero) begin
                    state_next = ST_DIVIDE;
                end else if (status.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN: begin
                cmd.write_sign = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/ssd_dp.sv @@
// datapath: pattern store, scan position, divide-by-ten unit, output registers
// depends on ssd_pkg
module ssd_dp
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [1:0]         s_digit_index,
    input  logic signed [4:0]  s_digit_value,
    input  logic               s_dot_on,
    input  logic signed [15:0] s_number,
    output logic [3:0]         m_digit_enable_n,
    output logic [7:0]         m_segments
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [7:0]        store_reg [NUM_DIGITS];
    logic [7:0]        store_next [NUM_DIGITS];
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [3:0]        rem_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              neg_reg;
    logic [3:0]        en_out_reg;
    logic [7:0]        seg_out_reg;

    logic [15:0]       abs_number;
    logic [26:0]       product;
    logic [QUOT_W-1:0] quot;
    logic [MAG_W-1:0]  times_ten;
    logic [MAG_W-1:0]  remainder;
    logic              value_ok;
    logic              index_ok;
    logic              pos_ok;
    logic [7:0]        digit_pattern;
    logic [3:0]        en_now;

    assign status.number_ok = (s_number > NUMBER_LOW) && (s_number < NUMBER_HIGH);
    assign status.quot_zero = (quot_reg == '0);
    assign status.negative  = neg_reg;

    // divide by ten through the reciprocal, exact below 16384
    assign abs_number = s_number[15] ? 16'(-s_number) : 16'(s_number);
    assign product    = mag_reg * RECIP_TEN;
    assign quot       = product[16 +: QUOT_W];
    assign times_ten  = MAG_W'({quot, 3'b000}) + MAG_W'({quot, 1'b0});
    assign remainder  = mag_reg - times_ten;

    assign value_ok = (s_digit_value >= VALUE_MIN) && (s_digit_value <= VALUE_MAX);
    assign index_ok = int'(s_digit_index) < NUM_DIGITS;
    assign pos_ok   = int'(pos_reg) < NUM_DIGITS;

    always_comb begin
        if (s_digit_value == VALUE_MIN) begin
            digit_pattern = MINUS_PATTERN;
        end else begin
            digit_pattern = glyph(s_digit_value[3:0]);
        end
        if (s_dot_on) begin
            digit_pattern = digit_pattern | DOT_MASK;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            en_now[i] = !(int'(scan_reg) == i);
        end
    end

    assign scan_next = (scan_reg == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_reg + 1'b1;

    always_comb begin
        store_next = store_reg;
        if (cmd.load_number) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                store_next[i] = '0;
            end
        end
        if (cmd.set_digit && value_ok && index_ok) begin
            store_next[IDX_W'(s_digit_index)] = digit_pattern;
        end
        if (cmd.write_digit && pos_ok) begin
            store_next[IDX_W'(pos_reg)] = glyph(rem_reg);
        end
        if (cmd.write_sign && pos_ok) begin
            store_next[IDX_W'(pos_reg)] = MINUS_PATTERN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                store_reg[i] <= '0;
            end
            scan_reg <= '0;
        end else begin
            store_reg <= store_next;
            if (cmd.tick) begin
                scan_reg <= scan_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_number) begin
            mag_reg <= abs_number[MAG_W-1:0];
            neg_reg <= s_number[15];
            pos_reg <= '0;
        end
        if (cmd.divide) begin
            quot_reg <= quot;
            rem_reg  <= remainder[3:0];
        end
        if (cmd.write_digit) begin
            mag_reg <= MAG_W'(quot_reg);
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.tick) begin
            en_out_reg  <= en_now;
            seg_out_reg <= store_reg[scan_reg];
        end
    end

    assign m_digit_enable_n = en_out_reg;
    assign m_segments       = seg_out_reg;

endmodule

@@ hdl/seven_segment_mux_display.sv @@
// Multiplexed seven-segment display driver. A tick loads the output register, and a new
// transaction is taken while that result waits unless it is another tick. A set-number
// transaction occupies the block while the divide-by-ten loop runs (one reciprocal
// multiply, then one store write, per decimal digit of the magnitude), then a minus-sign
// write for a negative number. Segment patterns reset to blank, scan to digit 0.
// top level: instantiates ssd_ctrl and ssd_dp, depends on ssd_pkg
module seven_segment_mux_display
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [1:0]         s_digit_index,
    input  logic signed [4:0]  s_digit_value,
    input  logic               s_dot_on,
    input  logic signed [15:0] s_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_digit_enable_n,
    output logic [7:0]         m_segments
);

    cmd_t    cmd;
    status_t status;

    ssd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    ssd_dp #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_digit_index    (s_digit_index),
        .s_digit_value    (s_digit_value),
        .s_dot_on         (s_dot_on),
        .s_number         (s_number),
        .m_digit_enable_n (m_digit_enable_n),
        .m_segments       (m_segments)
    );

endmodule

@@ hdl/ssd_checker.sv @@
// port-level checker for seven_segment_mux_display and its bind statement
// depends on ssd_pkg and seven_segment_mux_display_macros.svh
`include "seven_segment_mux_display_macros.svh"

module ssd_checker
    import ssd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_operation,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_digit_enable_n,
    input logic [7:0] m_segments
);

    // at most one digit enabled while a result is valid
    `SSD_ASSERT_IMPL(a_enable_one_cold, m_valid, $countones(m_digit_enable_n) >= 3, "more than one digit enabled")
    // an accepted tick always yields a result
    `SSD_ASSERT_NEXT(a_tick_result, s_valid && s_ready && (s_operation == OP_TICK), m_valid, "tick transaction gave no result")
    // no result right after reset
    `SSD_ASSERT_NEXT_RST(a_reset_idle, !aresetn, !m_valid, "result valid after reset")
    // stalled result keeps its payload
    `SSD_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_segments) && $stable(m_digit_enable_n), "stalled result changed")

endmodule

bind seven_segment_mux_display ssd_checker u_ssd_checker (.*);
